>>> rtl/bfkv_pkg.sv
// bfkv_pkg: shared types, character codes and result codes of the brace frame parser
// no dependencies; imported by bfkv_scan and the top level

package bfkv_pkg;

    // framing and separator characters
    localparam logic [7:0] CH_OPEN  = 8'h7B;  // left brace
    localparam logic [7:0] CH_CLOSE = 8'h7D;  // right brace
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // result kinds
    localparam logic [1:0] KIND_KV   = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // key/value items per frame, one slot is kept for the frame end item
    localparam int KV_CNT_W = 5;
    localparam logic [KV_CNT_W-1:0] MAX_KV = 5'd21;

    // field widths of the result transaction
    localparam int POS_W = 6;
    localparam int FLEN_W = 7;

    // one key/value item from the scanner
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] id_offset;
        logic [POS_W-1:0] id_length;
        logic [POS_W-1:0] value_offset;
        logic [POS_W-1:0] value_length;
    } kv_t;

    // one result transaction
    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [POS_W-1:0]  id_offset;
        logic [POS_W-1:0]  id_length;
        logic [POS_W-1:0]  value_offset;
        logic [POS_W-1:0]  value_length;
        logic [7:0]        read_data;
        logic [FLEN_W-1:0] frame_length;
        logic              last;
    } result_t;

    // characters that end a key or value run
    function automatic logic is_stop(input logic [7:0] x);
        return (x == CH_CLOSE) || (x == CH_COMMA) || (x == CH_QUOTE) || (x == CH_COLON);
    endfunction

    // characters that end a segment
    function automatic logic is_sep(input logic [7:0] x);
        return (x == CH_CLOSE) || (x == CH_COMMA);
    endfunction

endpackage

>>> rtl/bfkv_store.sv
// bfkv_store: frame store memory, one write port and one read port, registered read data
// depends on nothing but its parameters

module bfkv_store #(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bfkv_scan.sv
// bfkv_scan: walks a completed frame in the store and finds key/value segments
// depends on bfkv_pkg; reads the store through the top level's read port

module bfkv_scan
    import bfkv_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] fill,
    input  logic [7:0]    rd_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    output kv_t           kv,
    output logic          done
);

    typedef enum logic [3:0] {
        RUN_FIRST  = 4'b0001,  // next byte opens the run, one quote may be skipped
        RUN_SECOND = 4'b0010,  // next byte opens the run after a skipped quote
        RUN_ACTIVE = 4'b0100,
        RUN_DONE   = 4'b1000
    } run_t;

    typedef struct packed {
        run_t          st;
        logic [AW-1:0] off;
        logic [AW-1:0] len;
    } run_state_t;

    // advance one key or value run by one byte at position pos
    function automatic run_state_t run_step(input run_state_t cur, input logic [7:0] x,
                                            input logic [AW-1:0] pos);
        run_state_t r;
        logic stop;
        r = cur;
        stop = is_stop(x);
        case (cur.st)
            RUN_FIRST:
            begin
                r.off = pos;
                r.len = '0;
                if (x == CH_QUOTE)
                begin
                    r.off = pos + 1'b1;
                    r.st = RUN_SECOND;
                end
                else if (stop)
                begin
                    r.st = RUN_DONE;
                end
                else
                begin
                    r.len = AW'(1);
                    r.st = RUN_ACTIVE;
                end
            end
            RUN_SECOND:
            begin
                if (stop)
                begin
                    r.st = RUN_DONE;
                end
                else
                begin
                    r.len = AW'(1);
                    r.st = RUN_ACTIVE;
                end
            end
            RUN_ACTIVE:
            begin
                if (stop)
                begin
                    r.st = RUN_DONE;
                end
                else
                begin
                    r.len = cur.len + 1'b1;
                end
            end
            default:
            begin
                r = cur;
            end
        endcase
        return r;
    endfunction

    logic                issue_reg;
    logic [AW-1:0]       addr_reg;
    logic                dvalid_reg;
    logic [AW-1:0]       dpos_reg;
    logic                dlast_reg;
    logic                seg_first_reg, seg_first_next;
    logic                colon_reg, colon_next;
    run_state_t          key_reg, val_reg;
    run_state_t          key_cur, val_cur, key_start;
    logic [KV_CNT_W-1:0] count_reg, count_next;
    kv_t                 kv_reg, kv_next;
    logic                done_reg;
    logic                addr_last;

    assign addr_last = (addr_reg == AW'(fill - 1'b1));

    // read issue: positions 1 up to the closing brace
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            dvalid_reg <= 1'b0;
            dlast_reg <= 1'b0;
            done_reg <= 1'b0;
            kv_reg <= '0;
        end
        else
        begin
            if (start)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && addr_last)
            begin
                issue_reg <= 1'b0;
            end
            dvalid_reg <= issue_reg;
            dlast_reg <= issue_reg && addr_last;
            done_reg <= dvalid_reg && dlast_reg;
            kv_reg <= kv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addr_reg <= AW'(1);
        end
        else if (issue_reg)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
        dpos_reg <= addr_reg;
    end

    assign rd_en = issue_reg;
    assign rd_addr = addr_reg;

    // segment tracking on the byte returned by the store
    always_comb
    begin
        key_start.st = RUN_FIRST;
        key_start.off = '0;
        key_start.len = '0;
        key_cur = key_reg;
        val_cur = val_reg;
        seg_first_next = seg_first_reg;
        colon_next = colon_reg;
        count_next = count_reg;
        kv_next = '0;
        if (dvalid_reg)
        begin
            if (seg_first_reg)
            begin
                key_cur = run_step(key_start, rd_data, dpos_reg);
            end
            else
            begin
                key_cur = run_step(key_reg, rd_data, dpos_reg);
                if (colon_reg)
                begin
                    val_cur = run_step(val_reg, rd_data, dpos_reg);
                end
            end
            if (is_sep(rd_data))
            begin
                if (!seg_first_reg && colon_reg && (count_reg < MAX_KV))
                begin
                    kv_next.valid = 1'b1;
                    kv_next.id_offset = POS_W'(key_cur.off);
                    kv_next.id_length = POS_W'(key_cur.len);
                    kv_next.value_offset = POS_W'(val_cur.off);
                    kv_next.value_length = POS_W'(val_cur.len);
                    count_next = count_reg + 1'b1;
                end
                seg_first_next = 1'b1;
                colon_next = 1'b0;
            end
            else
            begin
                seg_first_next = 1'b0;
                if (!seg_first_reg && !colon_reg && (rd_data == CH_COLON))
                begin
                    colon_next = 1'b1;
                    val_cur.st = RUN_FIRST;
                end
            end
        end
    end

    // segment state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_first_reg <= 1'b1;
            colon_reg <= 1'b0;
            count_reg <= '0;
            key_reg.st <= RUN_DONE;
            key_reg.off <= '0;
            key_reg.len <= '0;
            val_reg.st <= RUN_DONE;
            val_reg.off <= '0;
            val_reg.len <= '0;
        end
        else if (start)
        begin
            seg_first_reg <= 1'b1;
            colon_reg <= 1'b0;
            count_reg <= '0;
            key_reg.st <= RUN_DONE;
            key_reg.off <= key_cur.off;
            key_reg.len <= key_cur.len;
            val_reg.st <= RUN_DONE;
            val_reg.off <= val_cur.off;
            val_reg.len <= val_cur.len;
        end
        else
        begin
            seg_first_reg <= seg_first_next;
            colon_reg <= colon_next;
            count_reg <= count_next;
            key_reg <= key_cur;
            val_reg <= val_cur;
        end
    end

    assign kv = kv_reg;
    assign done = done_reg;

endmodule

>>> rtl/brace_frame_key_value_parser_unit.sv
// brace_frame_key_value_parser_unit: top level, receive control, fill count and result register
// depends on bfkv_pkg, bfkv_store and bfkv_scan

// A transaction is taken when start is high and busy is low. A received byte (mode 0) does
// not raise busy and gives no result except for a closing brace that ends an open frame;
// that one walks the stored frame through the store's single read port, one byte per cycle,
// and busy stays high through the walk and the frame end state. It emits one key/value
// result per cycle as found, then a frame end result with last set and with fill, the count
// of stored bytes with both braces, as frame length. A read (mode 1) registers the store's
// read data and then its result from the S_READ state, with busy high in S_READ, so the next
// transaction is taken once the sequencer is back in S_IDLE. Results appear on the result
// ports for exactly one cycle under result_strobe and cannot be held off, so the receiver
// must take every strobed cycle. Store entries never written read back undefined.

module brace_frame_key_value_parser_unit
    import bfkv_pkg::*;
#(
    parameter int FRAME_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              mode,
    input  logic [7:0]        byte_in,
    input  logic [5:0]        read_address,
    output logic              result_strobe,
    output logic [1:0]        kind,
    output logic [POS_W-1:0]  id_offset,
    output logic [POS_W-1:0]  id_length,
    output logic [POS_W-1:0]  value_offset,
    output logic [POS_W-1:0]  value_length,
    output logic [7:0]        read_data,
    output logic [FLEN_W-1:0] frame_length,
    output logic              last
);

    localparam int AW = $clog2(FRAME_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_WALK = 4'b0100,
        S_END  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic          in_frame_reg, in_frame_next;
    logic          rd_zero_reg;
    result_t       out_reg, out_next;

    logic          accept, rx_accept, rd_accept, in_range;
    logic          is_open, is_close;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          st_rd_en;
    logic [AW-1:0] st_rd_addr;
    logic [7:0]    st_rd_data;
    logic          scan_start, scan_rd_en, scan_done;
    logic [AW-1:0] scan_rd_addr;
    kv_t           scan_kv;

    assign busy = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign rx_accept = accept && !mode;
    assign rd_accept = accept && mode;
    assign in_range = ({1'b0, read_address} < 7'(FRAME_DEPTH));
    assign is_open = (byte_in == CH_OPEN);
    assign is_close = (byte_in == CH_CLOSE);

    // receive path: store write, fill count and frame flag
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = fill_reg;
        fill_next = fill_reg;
        in_frame_next = in_frame_reg;
        scan_start = 1'b0;
        if (rx_accept)
        begin
            if (is_open)
            begin
                wr_en = 1'b1;
                wr_addr = '0;
                fill_next = AW'(1);
                in_frame_next = 1'b1;
            end
            else if (is_close)
            begin
                if (in_frame_reg)
                begin
                    wr_en = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    scan_start = 1'b1;
                end
                else
                begin
                    fill_next = '0;
                end
            end
            else if (in_frame_reg && (fill_reg < AW'(FRAME_DEPTH - 2)))
            begin
                wr_en = 1'b1;
                fill_next = fill_reg + 1'b1;
            end
        end
        if (state_reg == S_END)
        begin
            fill_next = '0;
            in_frame_next = 1'b0;
        end
    end

    // store read port shared by read transactions and the frame walk
    assign st_rd_en = (rd_accept && in_range) || scan_rd_en;
    assign st_rd_addr = rd_accept ? read_address[AW-1:0] : scan_rd_addr;

    bfkv_store #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (byte_in),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    bfkv_scan #(
        .AW (AW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .fill    (fill_reg),
        .rd_data (st_rd_data),
        .rd_en   (scan_rd_en),
        .rd_addr (scan_rd_addr),
        .kv      (scan_kv),
        .done    (scan_done)
    );

    // sequencer and result selection
    always_comb
    begin
        state_next = state_reg;
        out_next = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (rd_accept)
                begin
                    state_next = S_READ;
                end
                else if (scan_start)
                begin
                    state_next = S_WALK;
                end
            end
            S_READ:
            begin
                out_next.valid = 1'b1;
                out_next.kind = KIND_READ;
                out_next.read_data = rd_zero_reg ? 8'h00 : st_rd_data;
                out_next.last = 1'b1;
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (scan_kv.valid)
                begin
                    out_next.valid = 1'b1;
                    out_next.kind = KIND_KV;
                    out_next.id_offset = scan_kv.id_offset;
                    out_next.id_length = scan_kv.id_length;
                    out_next.value_offset = scan_kv.value_offset;
                    out_next.value_length = scan_kv.value_length;
                end
                if (scan_done)
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                out_next.valid = 1'b1;
                out_next.kind = KIND_END;
                out_next.frame_length = FLEN_W'(fill_reg);
                out_next.last = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            in_frame_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            in_frame_reg <= in_frame_next;
            out_reg <= out_next;
        end
    end

    // out of range read flag
    always_ff @(posedge clk)
    begin
        if (rd_accept)
        begin
            rd_zero_reg <= !in_range;
        end
    end

    assign result_strobe = out_reg.valid;
    assign kind = out_reg.kind;
    assign id_offset = out_reg.id_offset;
    assign id_length = out_reg.id_length;
    assign value_offset = out_reg.value_offset;
    assign value_length = out_reg.value_length;
    assign read_data = out_reg.read_data;
    assign frame_length = out_reg.frame_length;
    assign last = out_reg.last;

endmodule
